FILE: design/mse_pkg.sv
`timescale 1ns / 1ps
// Package for the MIPS-subset execute unit: payload structs, opcodes,
// controller states and controller/datapath command and status structs.
package mse_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_ADDI = 4'd4,
    OP_SUBI = 4'd5,
    OP_LW   = 4'd6,
    OP_SW   = 4'd7,
    OP_BEQ  = 4'd8,
    OP_J    = 4'd9
  } op_e;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_MISALIGN = 2'd1;
  localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

  localparam int unsigned SIG_J    = 1;
  localparam int unsigned SIG_BEQ  = 2;
  localparam int unsigned SIG_MEM  = 3;
  localparam int unsigned SIG_ALU  = 5;
  localparam int unsigned SIG_MAIN = 8;

  localparam logic [9:0] ENABLES_RESET = 10'h3FF;
  localparam logic [0:0] REG_SIGNAL_ENABLES = 1'b0;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_a;
    logic [4:0]  src_reg_b;
    logic signed [31:0] immediate;
    logic [11:0] byte_offset;
    logic [9:0]  target_index;
  } req_t;

  typedef struct packed {
    logic        branch_taken;
    logic [9:0]  branch_target;
    logic        reg_written;
    logic [4:0]  written_index;
    logic signed [31:0] written_value;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_MUL,
    ST_FINISH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic read;
    logic div_start;
    logic div_step;
    logic mul_step;
    logic finish;
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_div;
    logic need_mul;
    logic div_done;
  } sts_t;

endpackage

FILE: design/mips_subset_execute_unit.sv
`timescale 1ns / 1ps
// Top level of the MIPS-subset execute unit: APB register, controller, datapath.
// Depends on mse_pkg, mse_ctrl and mse_datapath.
//
//   channel  | handshake             | payload
//   input    | in_valid_i/in_ready_o | in_data_i  (mse_pkg::req_t)
//   output   | out_valid_o/out_ready_i | out_data_o (mse_pkg::rsp_t)
//   config   | APB psel/penable      | signal_enables at 0x0
//
// One instruction at a time: after accept the controller steps through READ, then MUL for
// mul or the 1-bit divider loop in DIV for div, then FINISH and OUT with the result.
// A new item is taken only in IDLE, or in OUT as the result leaves to a ready receiver.
// After reset a sweep clears every data memory word; no transfer is taken meanwhile.
// A stalled result holds the unit; the next item is taken as the result leaves.
module mips_subset_execute_unit #(
  parameter int unsigned MEM_WORDS     = 1024,
  parameter int unsigned PROGRAM_DEPTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mse_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mse_pkg::rsp_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [0:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [9:0]    enables_q;
  mse_pkg::cmd_t cmd;
  mse_pkg::sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == mse_pkg::REG_SIGNAL_ENABLES) ? {22'd0, enables_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enables_q <= mse_pkg::ENABLES_RESET;
    end else if (psel && penable && pwrite && paddr == mse_pkg::REG_SIGNAL_ENABLES) begin
      enables_q <= pwdata[9:0];
    end
  end

  mse_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  mse_datapath #(.MEM_WORDS(MEM_WORDS), .PROGRAM_DEPTH(PROGRAM_DEPTH)) u_dp (
    .clk_i, .rst_ni, .enables_i(enables_q), .req_i(in_data_i),
    .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );

endmodule

FILE: design/mse_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the execute unit.
// Depends on mse_pkg; drives the datapath through mse_pkg::cmd_t.
module mse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  mse_pkg::sts_t  sts_i,
  output mse_pkg::cmd_t  cmd_o
);

  mse_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mse_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mse_pkg::ST_CLEAR:  if (sts_i.clear_done) state_d = mse_pkg::ST_IDLE;
      mse_pkg::ST_IDLE:   if (in_valid_i) state_d = mse_pkg::ST_READ;
      mse_pkg::ST_READ: begin
        if (sts_i.need_div)      state_d = mse_pkg::ST_DIV;
        else if (sts_i.need_mul) state_d = mse_pkg::ST_MUL;
        else                     state_d = mse_pkg::ST_FINISH;
      end
      mse_pkg::ST_DIV:    if (sts_i.div_done) state_d = mse_pkg::ST_FINISH;
      mse_pkg::ST_MUL:    state_d = mse_pkg::ST_FINISH;
      mse_pkg::ST_FINISH: state_d = mse_pkg::ST_OUT;
      mse_pkg::ST_OUT: begin
        if (out_ready_i) state_d = in_valid_i ? mse_pkg::ST_READ : mse_pkg::ST_IDLE;
      end
      default:            state_d = mse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mse_pkg::ST_CLEAR: cmd_o.clear_step = 1'b1;
      mse_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      mse_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        cmd_o.div_start = sts_i.need_div;
      end
      mse_pkg::ST_DIV:    cmd_o.div_step = 1'b1;
      mse_pkg::ST_MUL:    cmd_o.mul_step = 1'b1;
      mse_pkg::ST_FINISH: cmd_o.finish = 1'b1;
      mse_pkg::ST_OUT: begin
        cmd_o.out_valid = 1'b1;
        in_ready_o = out_ready_i;
        cmd_o.load = out_ready_i && in_valid_i;
      end
      default: ;
    endcase
  end

  assign out_valid_o = cmd_o.out_valid;

endmodule

FILE: design/mse_datapath.sv
`timescale 1ns / 1ps
// Datapath of the execute unit: register file, data memory, ALU,
// radix-2 divider and split multiplier. Depends on mse_pkg.
module mse_datapath #(
  parameter int unsigned MEM_WORDS     = 1024,
  parameter int unsigned PROGRAM_DEPTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [9:0]    enables_i,
  input  mse_pkg::req_t req_i,
  input  mse_pkg::cmd_t cmd_i,
  output mse_pkg::sts_t sts_o,
  output mse_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned TW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;

  logic [31:0] rf_q [32];
  logic [31:0] mem_q [MEM_WORDS];

  mse_pkg::req_t req_q;
  logic [31:0] va_q, vb_q, vd_q, mrd_q;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] widx;
  logic        en_alu, en_imm, en_mem, en_beq, en_j, aligned;

  // divider
  logic [31:0] dq_q, dr_q, dd_q;
  logic [5:0]  dcnt_q;
  logic        dneg_q;
  logic [32:0] dsub;
  // multiplier: lo*lo and cross products
  logic [31:0] mlo_q;
  logic [15:0] mx_q;

  logic [31:0] res_val;
  logic        res_wr;
  logic [1:0]  res_st;
  mse_pkg::rsp_t rsp_q;

  assign en_alu = enables_i[mse_pkg::SIG_MAIN] | enables_i[mse_pkg::SIG_ALU];
  assign en_imm = enables_i[mse_pkg::SIG_MAIN];
  assign en_mem = enables_i[mse_pkg::SIG_MEM];
  assign en_beq = enables_i[mse_pkg::SIG_BEQ] | enables_i[mse_pkg::SIG_MAIN];
  assign en_j   = enables_i[mse_pkg::SIG_J];
  assign aligned = (req_q.byte_offset[1:0] == 2'b00);
  assign widx   = AW'({20'd0, req_q.byte_offset[11:2]} % MEM_WORDS);

  assign sts_o.clear_done = (clr_q == AW'(MEM_WORDS - 1));
  assign sts_o.need_div   = (req_q.req_type == mse_pkg::OP_DIV) && en_alu;
  assign sts_o.need_mul   = (req_q.req_type == mse_pkg::OP_MUL) && en_alu;
  assign sts_o.div_done   = (dcnt_q == 6'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  // register file: 32 registers in flops, reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) rf_q[i] <= '0;
    end else if (cmd_i.finish && res_wr) begin
      rf_q[req_q.dest_reg] <= res_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      va_q <= (req_q.src_reg_a == 5'd0) ? 32'd0 : rf_q[req_q.src_reg_a];
      vb_q <= (req_q.src_reg_b == 5'd0) ? 32'd0 : rf_q[req_q.src_reg_b];
      vd_q <= (req_q.dest_reg == 5'd0) ? 32'd0 : rf_q[req_q.dest_reg];
    end
  end

  // data memory: cleared by sweep after reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      mem_q[clr_q] <= '0;
    end else if (cmd_i.finish && req_q.req_type == mse_pkg::OP_SW && en_mem && aligned) begin
      mem_q[widx] <= vd_q;
    end
    if (cmd_i.read) mrd_q <= mem_q[widx];
  end

  // restoring divider on magnitudes, one quotient bit per cycle
  assign dsub = {dr_q[31:0], dq_q[31]} - {1'b0, dd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= 6'd32;
    end else if (cmd_i.div_step && dcnt_q != 6'd0) begin
      dcnt_q <= dcnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      logic [31:0] a, b;
      a = (req_q.src_reg_a == 5'd0) ? 32'd0 : rf_q[req_q.src_reg_a];
      b = (req_q.src_reg_b == 5'd0) ? 32'd0 : rf_q[req_q.src_reg_b];
      dq_q   <= a[31] ? 32'(-a) : a;
      dd_q   <= b[31] ? 32'(-b) : b;
      dr_q   <= '0;
      dneg_q <= a[31] ^ b[31];
    end else if (cmd_i.div_step && dcnt_q != 6'd0) begin
      if (!dsub[32]) begin
        dr_q <= dsub[31:0];
        dq_q <= {dq_q[30:0], 1'b1};
      end else begin
        dr_q <= {dr_q[30:0], dq_q[31]};
        dq_q <= {dq_q[30:0], 1'b0};
      end
    end
  end

  // 32x32 low product from 16x16 pieces
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      mlo_q <= {16'd0, va_q[15:0]} * {16'd0, vb_q[15:0]};
      mx_q  <= 16'(va_q[31:16] * vb_q[15:0]) + 16'(va_q[15:0] * vb_q[31:16]);
    end
  end

  always_comb begin
    res_val = '0;
    res_wr  = 1'b0;
    res_st  = mse_pkg::STATUS_OK;
    case (req_q.req_type)
      mse_pkg::OP_ADD, mse_pkg::OP_SUB, mse_pkg::OP_MUL, mse_pkg::OP_DIV: begin
        if (en_alu) begin
          res_wr = 1'b1;
          case (req_q.req_type)
            mse_pkg::OP_ADD: res_val = va_q + vb_q;
            mse_pkg::OP_SUB: res_val = va_q - vb_q;
            mse_pkg::OP_MUL: res_val = mlo_q + {mx_q, 16'd0};
            default: begin
              if (vb_q == 32'd0) begin
                res_st = mse_pkg::STATUS_DIV_ZERO;
              end else begin
                res_val = dneg_q ? 32'(-dq_q) : dq_q;
              end
            end
          endcase
        end
      end
      mse_pkg::OP_ADDI: if (en_imm) begin res_wr = 1'b1; res_val = va_q + req_q.immediate; end
      mse_pkg::OP_SUBI: if (en_imm) begin res_wr = 1'b1; res_val = va_q - req_q.immediate; end
      mse_pkg::OP_LW, mse_pkg::OP_SW: begin
        if (en_mem) begin
          if (!aligned) res_st = mse_pkg::STATUS_MISALIGN;
          else if (req_q.req_type == mse_pkg::OP_LW) begin
            res_wr = 1'b1;
            res_val = mrd_q;
          end
        end
      end
      default: ;
    endcase
    if (req_q.dest_reg == 5'd0) res_wr = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      logic tk;
      tk = ((req_q.req_type == mse_pkg::OP_BEQ) && en_beq && (vd_q == va_q)) ||
           ((req_q.req_type == mse_pkg::OP_J) && en_j);
      rsp_q.branch_taken  <= tk;
      rsp_q.branch_target <= tk ? 10'(TW'({22'd0, req_q.target_index} % PROGRAM_DEPTH))
                                : 10'd0;
      rsp_q.reg_written   <= res_wr;
      rsp_q.written_index <= res_wr ? req_q.dest_reg : 5'd0;
      rsp_q.written_value <= res_wr ? res_val : 32'd0;
      rsp_q.status        <= res_st;
    end
  end

  assign rsp_o = rsp_q;

endmodule

FILE: design/mse_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the execute unit, bound to the top level.
// Depends on mse_pkg.
module mse_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input mse_pkg::rsp_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.reg_written && out_data_o.written_index == 5'd0))
    else $error("write to register zero reported");

  a_status_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == mse_pkg::STATUS_MISALIGN |-> !out_data_o.reg_written)
    else $error("misaligned access wrote a register");

  a_accept_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result valid right after accept");

endmodule

bind mips_subset_execute_unit mse_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
